// ----- sv/aomd_pkg.sv -----
// Shared types, field widths and codes for the orientation and motion detector.
package aomd_pkg;

    // Sample and result field widths
    localparam int AXIS_W   = 12;
    localparam int ORIENT_W = 2;
    localparam int MODE_W   = 2;
    localparam int S_DATA_W = 40;   // three axes, 36 bits, padded to whole bytes
    localparam int M_DATA_W = 8;    // four result bits, padded to one byte

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic [ORIENT_W-1:0]      orient_t;
    typedef logic [MODE_W-1:0]        mode_t;
    typedef logic [AXIS_W-1:0]        mag_t;

    // Orientation codes
    localparam orient_t ORIENT_Y_POS = 2'd0;
    localparam orient_t ORIENT_X_POS = 2'd1;
    localparam orient_t ORIENT_Y_NEG = 2'd2;
    localparam orient_t ORIENT_X_NEG = 2'd3;

    // Sensitivity modes
    localparam mode_t MODE_OFF  = 2'd0;
    localparam mode_t MODE_LOW  = 2'd1;
    localparam mode_t MODE_MED  = 2'd2;
    localparam mode_t MODE_HIGH = 2'd3;

    // Motion thresholds; off mode exceeds any 12-bit delta, so it is gated instead
    localparam mag_t THR_LOW  = 12'd1400;
    localparam mag_t THR_MED  = 12'd800;
    localparam mag_t THR_HIGH = 12'd200;

    // Orientation decision limits
    localparam axis_t AXIS_MAJOR     = 12'sd200;
    localparam axis_t AXIS_MAJOR_NEG = -12'sd200;
    localparam axis_t AXIS_MINOR     = 12'sd120;
    localparam axis_t AXIS_MINOR_NEG = -12'sd120;

    // Result byte bit positions
    localparam int RES_ORIENT_LSB = 0;
    localparam int RES_CHANGED    = 2;
    localparam int RES_MOVED      = 3;

endpackage

// ----- sv/accel_orientation_motion_detect_top.sv -----
// Orientation and motion detector: one result per three-axis accelerometer sample.
//
// Each request on the s_ channel carries one signed 12-bit sample per axis and
// produces exactly one result on the m_ channel: the portrait/landscape code,
// a flag when that code changed, and a flag when any axis moved by more than
// the threshold of the selected sensitivity mode (never in off mode). A sample is
// taken every clock cycle unless the full input register cannot drain into the
// result register; samples pass the input register, then the result register.
// The user must write the sensitivity mode through the cfg_ port only while the
// block is idle; the block itself does not enforce this.
module accel_orientation_motion_detect_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Sensitivity mode write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [aomd_pkg::MODE_W-1:0]   cfg_data,
    // Sample input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [aomd_pkg::S_DATA_W-1:0] s_tdata,  // accel_x[11:0], accel_y[23:12],
                                                    // accel_z[35:24], zeros[39:36]
    // Result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [aomd_pkg::M_DATA_W-1:0] m_tdata   // orientation[1:0],
                                                    // orientation_changed[2],
                                                    // moved[3], zeros[7:4]
);

    aomd_pkg::mode_t   mode_reg;
    logic              in_valid_reg;
    aomd_pkg::axis_t   x_reg, y_reg, z_reg;
    aomd_pkg::axis_t   last_x_reg, last_y_reg, last_z_reg;
    aomd_pkg::orient_t last_orient_reg;
    logic              out_valid_reg;
    aomd_pkg::orient_t out_orient_reg;
    logic              out_changed_reg;
    logic              out_moved_reg;

    logic              load_out;
    aomd_pkg::orient_t orient_next;
    logic              changed_next;
    logic              moved_next;
    logic signed [aomd_pkg::AXIS_W:0] dx, dy, dz;
    aomd_pkg::mag_t    mx, my, mz;
    aomd_pkg::mag_t    thr;
    logic              x_small, y_small, z_small;

    // Handshake: result register loads when empty or being drained
    assign load_out  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || load_out;
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= aomd_pkg::MODE_OFF;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            x_reg <= s_tdata[11:0];
            y_reg <= s_tdata[23:12];
            z_reg <= s_tdata[35:24];
        end
    end

    // Orientation decision: x or y strong, the other two axes small; else it holds
    always_comb begin
        x_small = (x_reg < aomd_pkg::AXIS_MINOR) && (x_reg > aomd_pkg::AXIS_MINOR_NEG);
        y_small = (y_reg < aomd_pkg::AXIS_MINOR) && (y_reg > aomd_pkg::AXIS_MINOR_NEG);
        z_small = (z_reg < aomd_pkg::AXIS_MINOR) && (z_reg > aomd_pkg::AXIS_MINOR_NEG);
        orient_next = last_orient_reg;
        if (y_reg > aomd_pkg::AXIS_MAJOR && x_small && z_small) begin
            orient_next = aomd_pkg::ORIENT_Y_POS;
        end else if (x_reg > aomd_pkg::AXIS_MAJOR && y_small && z_small) begin
            orient_next = aomd_pkg::ORIENT_X_POS;
        end else if (y_reg < aomd_pkg::AXIS_MAJOR_NEG && x_small && z_small) begin
            orient_next = aomd_pkg::ORIENT_Y_NEG;
        end else if (x_reg < aomd_pkg::AXIS_MAJOR_NEG && y_small && z_small) begin
            orient_next = aomd_pkg::ORIENT_X_NEG;
        end
        changed_next = (orient_next != last_orient_reg);
    end

    // Per-axis delta magnitude; fits 12 bits unsigned (at most 4095)
    always_comb begin
        dx = {x_reg[aomd_pkg::AXIS_W-1], x_reg} - {last_x_reg[aomd_pkg::AXIS_W-1], last_x_reg};
        dy = {y_reg[aomd_pkg::AXIS_W-1], y_reg} - {last_y_reg[aomd_pkg::AXIS_W-1], last_y_reg};
        dz = {z_reg[aomd_pkg::AXIS_W-1], z_reg} - {last_z_reg[aomd_pkg::AXIS_W-1], last_z_reg};
        mx = dx[aomd_pkg::AXIS_W] ? aomd_pkg::mag_t'(-dx) : aomd_pkg::mag_t'(dx);
        my = dy[aomd_pkg::AXIS_W] ? aomd_pkg::mag_t'(-dy) : aomd_pkg::mag_t'(dy);
        mz = dz[aomd_pkg::AXIS_W] ? aomd_pkg::mag_t'(-dz) : aomd_pkg::mag_t'(dz);
    end

    // Threshold select and motion compare
    always_comb begin
        unique case (mode_reg)
            aomd_pkg::MODE_LOW:  thr = aomd_pkg::THR_LOW;
            aomd_pkg::MODE_MED:  thr = aomd_pkg::THR_MED;
            aomd_pkg::MODE_HIGH: thr = aomd_pkg::THR_HIGH;
            default:             thr = aomd_pkg::THR_LOW;
        endcase
        moved_next = (mode_reg != aomd_pkg::MODE_OFF) &&
                     ((mx > thr) || (my > thr) || (mz > thr));
    end

    // History: updated as each sample moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            last_z_reg      <= '0;
            last_orient_reg <= aomd_pkg::ORIENT_Y_POS;
        end else if (load_out) begin
            last_x_reg      <= x_reg;
            last_y_reg      <= y_reg;
            last_z_reg      <= z_reg;
            last_orient_reg <= orient_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_orient_reg  <= orient_next;
            out_changed_reg <= changed_next;
            out_moved_reg   <= moved_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_moved_reg, out_changed_reg, out_orient_reg};

endmodule

// ----- sv/aomd_checker.sv -----
// Port-level checker for the orientation and motion detector, with its bind.
module aomd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [aomd_pkg::MODE_W-1:0]   cfg_data,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [aomd_pkg::M_DATA_W-1:0] m_tdata
);

    aomd_pkg::mode_t   mode_reg;
    aomd_pkg::orient_t prev_orient_reg;
    logic              out_acc;
    logic              s_acc;

    assign out_acc = m_tvalid && m_tready;
    assign s_acc   = s_tvalid && s_tready;

    // Shadow of the mode and of the last delivered orientation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= aomd_pkg::MODE_OFF;
            prev_orient_reg <= aomd_pkg::ORIENT_Y_POS;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            if (out_acc) begin
                prev_orient_reg <= m_tdata[1:0];
            end
        end
    end

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result appears right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Change flag agrees with the previously delivered orientation
    a_changed: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> m_tdata[aomd_pkg::RES_CHANGED] ==
                    (m_tdata[1:0] != prev_orient_reg))
        else $error("orientation_changed inconsistent");

    // Off mode never reports motion
    a_off: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && mode_reg == aomd_pkg::MODE_OFF |-> !m_tdata[aomd_pkg::RES_MOVED])
        else $error("motion reported in off mode");

    // A sample accepted with no result pending gives a valid result once it has passed the input and result registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && !m_tvalid |=> ##1 m_tvalid)
        else $error("result missing after sample");

endmodule

bind accel_orientation_motion_detect_top aomd_checker u_aomd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
